/* sv/fbc_pkg.sv */
// Shared types and constants for the free block cache.
// Used by the register file, controller, datapath and top level.
package fbc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = 5;
  localparam int CNT_W       = 6;
  localparam int DATA_W      = 32;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_FREE     = 3'd1;
  localparam logic [2:0] CMD_DELIVER  = 3'd2;
  localparam logic [2:0] CMD_FILL_END = 3'd3;
  localparam logic [2:0] CMD_FILL_REQ = 3'd4;
  localparam logic [2:0] CMD_FLUSH    = 3'd5;

  localparam logic [2:0] K_GRANT   = 3'd0;
  localparam logic [2:0] K_FILL    = 3'd1;
  localparam logic [2:0] K_SPILL   = 3'd2;
  localparam logic [2:0] K_BYPASS  = 3'd3;
  localparam logic [2:0] K_ACK     = 3'd4;
  localparam logic [2:0] K_REFUSED = 3'd5;

  localparam logic [1:0] REG_MAX    = 2'd0;
  localparam logic [1:0] REG_BATCH  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [CNT_W-1:0] RST_MAX    = 6'd32;
  localparam logic [CNT_W-1:0] RST_BATCH  = 6'd16;
  localparam logic [CNT_W-1:0] RST_THRESH = 6'd16;
  localparam logic [CNT_W-1:0] RECV_SAT   = 6'd63;

  localparam logic [1:0] ASEL_ZERO  = 2'd0;
  localparam logic [1:0] ASEL_RDATA = 2'd1;
  localparam logic [1:0] ASEL_ITEM  = 2'd2;

  localparam logic [1:0] CSEL_ZERO = 2'd0;
  localparam logic [1:0] CSEL_NEED = 2'd1;
  localparam logic [1:0] CSEL_RECV = 2'd2;

  localparam logic [1:0] NSEL_ONE  = 2'd0;
  localparam logic [1:0] NSEL_FREE = 2'd1;
  localparam logic [1:0] NSEL_HELD = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] max_eff;
    logic [CNT_W-1:0] batch_eff;
    logic [CNT_W-1:0] thresh;
  } fbc_cfg_t;

  typedef struct packed {
    logic       latch;
    logic       rd;
    logic       emit;
    logic [2:0] kind;
    logic [1:0] asel;
    logic [1:0] csel;
    logic       last;
    logic       held_dec;
    logic       push;
    logic       cnt_ld;
    logic [1:0] nsel;
    logic       cnt_dec;
    logic       recv_clr;
    logic       recv_inc;
    logic       pend_set;
    logic       pend_clr;
    logic       wait_set;
    logic       wait_clr;
  } fbc_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       addr_zero;
    logic       held_zero;
    logic       held_full;
    logic       spill_now;
    logic       need_zero;
    logic       pending;
    logic       waiting;
    logic       cnt_one;
    logic       out_free;
  } fbc_sts_t;

endpackage

/* sv/fbc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/fbc_regs.sv */
// Configuration registers behind the APB-style port, and the effective limits.
// Depends on fbc_pkg.
module fbc_regs import fbc_pkg::*; #(
  parameter int CACHE_LIMIT   = 32,
  parameter int DEFAULT_BATCH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output fbc_cfg_t          cfg
);

  localparam int MAXC_I = (CACHE_LIMIT < STACK_DEPTH) ? CACHE_LIMIT : STACK_DEPTH;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAXC_I);
  localparam logic [CNT_W-1:0] DEFB = CNT_W'(DEFAULT_BATCH);

  logic [CNT_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0] batch_r, batch_nxt;
  logic [CNT_W-1:0] thresh_r, thresh_nxt;
  logic [CNT_W-1:0] max_eff, batch_raw;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    max_nxt    = max_r;
    batch_nxt  = batch_r;
    thresh_nxt = thresh_r;
    if (wr) begin
      case (cfg_paddr[3:2])
        REG_MAX:    max_nxt    = cfg_pwdata[CNT_W-1:0];
        REG_BATCH:  batch_nxt  = cfg_pwdata[CNT_W-1:0];
        REG_THRESH: thresh_nxt = cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= RST_MAX;
      batch_r  <= RST_BATCH;
      thresh_r <= RST_THRESH;
    end else begin
      max_r    <= max_nxt;
      batch_r  <= batch_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MAX:    cfg_prdata = CFG_DW'(max_r);
      REG_BATCH:  cfg_prdata = CFG_DW'(batch_r);
      REG_THRESH: cfg_prdata = CFG_DW'(thresh_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign max_eff   = (max_r == '0 || max_r > MAXC) ? MAXC : max_r;
  assign batch_raw = (batch_r == '0) ? DEFB : batch_r;

  assign cfg.max_eff   = max_eff;
  assign cfg.batch_eff = (batch_raw > max_eff) ? max_eff : batch_raw;
  assign cfg.thresh    = thresh_r;

endmodule

/* sv/fbc_ctrl.sv */
// Controller state machine: decodes each item and sequences pops, spills and pushes.
// Depends on fbc_pkg; drives the datapath through fbc_cmd_t.
module fbc_ctrl import fbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  fbc_sts_t sts,
  output fbc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_TAIL   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       refuse;
  logic       grant_pop;

  always_comb begin
    case (sts.op)
      CMD_ALLOC, CMD_FREE, CMD_FILL_REQ, CMD_FLUSH: refuse = sts.pending;
      CMD_DELIVER, CMD_FILL_END:                    refuse = !sts.pending;
      default:                                      refuse = 1'b1;
    endcase
  end

  assign grant_pop = (sts.op == CMD_ALLOC) || (sts.op == CMD_FILL_END);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          cmd.rd    = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          cmd.last  = 1'b1;
          if (refuse) begin
            cmd.emit = 1'b1;
            cmd.kind = K_REFUSED;
          end else begin
            case (sts.op)
              CMD_ALLOC: begin
                if (!sts.held_zero) begin
                  cmd.cnt_ld = 1'b1;
                  cmd.nsel   = NSEL_ONE;
                  state_nxt  = S_POP;
                end else if (sts.need_zero) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_BYPASS;
                end else begin
                  cmd.emit     = 1'b1;
                  cmd.kind     = K_FILL;
                  cmd.csel     = CSEL_NEED;
                  cmd.pend_set = 1'b1;
                  cmd.wait_set = 1'b1;
                  cmd.recv_clr = 1'b1;
                end
              end
              CMD_FREE: begin
                if (sts.addr_zero) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_ACK;
                end else if (sts.spill_now) begin
                  cmd.cnt_ld = 1'b1;
                  cmd.nsel   = NSEL_FREE;
                  state_nxt  = S_POP;
                end else begin
                  state_nxt = S_TAIL;
                end
              end
              CMD_DELIVER: begin
                cmd.emit = 1'b1;
                if (sts.addr_zero) begin
                  cmd.kind = K_ACK;
                  cmd.csel = CSEL_RECV;
                end else if (sts.held_full) begin
                  cmd.kind = K_SPILL;
                  cmd.asel = ASEL_ITEM;
                end else begin
                  cmd.kind     = K_ACK;
                  cmd.csel     = CSEL_RECV;
                  cmd.push     = 1'b1;
                  cmd.recv_inc = 1'b1;
                end
              end
              CMD_FILL_END: begin
                cmd.pend_clr = 1'b1;
                if (sts.waiting) begin
                  cmd.wait_clr = 1'b1;
                  if (sts.held_zero) begin
                    cmd.emit = 1'b1;
                    cmd.kind = K_BYPASS;
                  end else begin
                    cmd.cnt_ld = 1'b1;
                    cmd.nsel   = NSEL_ONE;
                    state_nxt  = S_POP;
                  end
                end else begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_ACK;
                  cmd.csel = CSEL_RECV;
                end
              end
              CMD_FILL_REQ: begin
                cmd.emit = 1'b1;
                if (sts.need_zero) begin
                  cmd.kind = K_ACK;
                end else begin
                  cmd.kind     = K_FILL;
                  cmd.csel     = CSEL_NEED;
                  cmd.pend_set = 1'b1;
                  cmd.wait_clr = 1'b1;
                  cmd.recv_clr = 1'b1;
                end
              end
              CMD_FLUSH: begin
                if (sts.held_zero) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_ACK;
                end else begin
                  cmd.cnt_ld = 1'b1;
                  cmd.nsel   = NSEL_HELD;
                  state_nxt  = S_POP;
                end
              end
              default: begin
                cmd.emit = 1'b1;
                cmd.kind = K_REFUSED;
              end
            endcase
          end
        end
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = grant_pop ? K_GRANT : K_SPILL;
          cmd.asel     = ASEL_RDATA;
          cmd.last     = sts.cnt_one && (sts.op != CMD_FREE);
          cmd.held_dec = 1'b1;
          cmd.cnt_dec  = 1'b1;
          if (!sts.cnt_one) begin
            cmd.rd = 1'b1;
          end else if (sts.op == CMD_FREE) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
          if (sts.held_full) begin
            cmd.kind = K_SPILL;
            cmd.asel = ASEL_ITEM;
          end else begin
            cmd.kind = K_ACK;
            cmd.push = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/fbc_dp.sv */
// Datapath: held item, block stack RAM, counters, fill flags and the output register.
// Depends on fbc_pkg and fbc_ram; takes commands from fbc_ctrl.
module fbc_dp import fbc_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fbc_cfg_t          cfg,
  input  fbc_cmd_t          cmd,
  output fbc_sts_t          sts,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic [2:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  localparam int AW = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;

  logic [2:0]        op_r;
  logic [AW-1:0]     item_r;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  recv_r, recv_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              wait_r, wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]  out_req_r, out_req_nxt;
  logic [CNT_W-1:0]  out_cached_r;
  logic              out_full_r;
  logic [2:0]        out_kind_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  room, need, keep, half_max, free_raw, free_n, rd_ptr;
  logic [AW-1:0]     rdata;
  logic              held_full;
  logic              out_free;

  fbc_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (held_r[SP_W-1:0]),
    .wdata (item_r),
    .re    (cmd.rd),
    .raddr (rd_ptr[SP_W-1:0]),
    .rdata (rdata)
  );

  assign held_full = held_r >= cfg.max_eff;
  assign room      = held_full ? '0 : cfg.max_eff - held_r;
  assign need      = (cfg.batch_eff < room) ? cfg.batch_eff : room;
  assign half_max  = cfg.max_eff >> 1;
  assign keep      = (cfg.thresh > half_max) ? half_max : cfg.thresh;
  assign free_raw  = held_r - keep;
  assign free_n    = (free_raw > cfg.batch_eff) ? cfg.batch_eff : free_raw;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    held_nxt = held_r;
    if (cmd.held_dec) begin
      held_nxt = held_r - 6'd1;
    end else if (cmd.push) begin
      held_nxt = held_r + 6'd1;
    end
  end
  assign rd_ptr = held_nxt - 6'd1;

  always_comb begin
    recv_nxt = recv_r;
    if (cmd.recv_clr) begin
      recv_nxt = '0;
    end else if (cmd.recv_inc && recv_r != RECV_SAT) begin
      recv_nxt = recv_r + 6'd1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_ld) begin
      case (cmd.nsel)
        NSEL_FREE: cnt_nxt = free_n;
        NSEL_HELD: cnt_nxt = held_r;
        default:   cnt_nxt = 6'd1;
      endcase
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (cmd.pend_set) begin
      pend_nxt = 1'b1;
    end else if (cmd.pend_clr) begin
      pend_nxt = 1'b0;
    end
    wait_nxt = wait_r;
    if (cmd.wait_set) begin
      wait_nxt = 1'b1;
    end else if (cmd.wait_clr) begin
      wait_nxt = 1'b0;
    end
  end

  always_comb begin
    case (cmd.asel)
      ASEL_RDATA: out_addr_nxt = DATA_W'(rdata);
      ASEL_ITEM:  out_addr_nxt = DATA_W'(item_r);
      default:    out_addr_nxt = '0;
    endcase
    case (cmd.csel)
      CSEL_NEED: out_req_nxt = need;
      CSEL_RECV: out_req_nxt = recv_nxt;
      default:   out_req_nxt = '0;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      recv_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      recv_r      <= recv_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_tuser;
      item_r <= in_tdata[AW-1:0];
    end
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_addr_r   <= out_addr_nxt;
      out_req_r    <= out_req_nxt;
      out_last_r   <= cmd.last;
      out_cached_r <= held_nxt;
      out_full_r   <= held_nxt >= cfg.max_eff;
    end
  end

  assign sts.op        = op_r;
  assign sts.addr_zero = (item_r == '0);
  assign sts.held_zero = (held_r == '0);
  assign sts.held_full = held_full;
  assign sts.spill_now = held_full && (held_r > cfg.thresh);
  assign sts.need_zero = (need == '0);
  assign sts.pending   = pend_r;
  assign sts.waiting   = wait_r;
  assign sts.cnt_one   = (cnt_r == 6'd1);
  assign sts.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_full_r, out_cached_r, out_req_r, out_addr_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/free_block_cache_with_batch_refill_core.sv */
// Free block cache top level: a LIFO of free block addresses in front of a global pool.
// Depends on fbc_pkg, fbc_regs, fbc_ctrl, fbc_dp and fbc_ram.
//
// One item is taken at a time. Results leave through an output register, so the next item
// is accepted while the last result of the previous one still waits. An item that answers
// with a single result straight from the decode (ack, refusal, fill request, bypass, or a
// delivered block spilled back) is latched in the idle state and has its result registered
// from the decide state. A grant from the stack is emitted from the stack's registered read
// port, read at accept, in the pop state; a free of a nonzero block pushes or spills it in
// the tail state after the spill decision. A spill run or a flush-all emits one block per
// cycle while the output is free. No clearing pass after reset: stack entries are used only
// after they are written.
module free_block_cache_with_batch_refill_core import fbc_pkg::*; #(
  parameter int CACHE_LIMIT   = 32,
  parameter int DEFAULT_BATCH = 16,
  parameter int ADDR_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // block_addr[31:0]
  input  logic [2:0]        in_tuser,    // command[2:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,   // out_addr[31:0], req_count[37:32],
                                         // cached_now[43:38], is_full[44], zero[47:45]
  output logic [2:0]        out_tuser,   // kind[2:0]
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int REQ_LSB    = DATA_W;
  localparam int CACHED_LSB = DATA_W + CNT_W;

  fbc_cfg_t cfg;
  fbc_cmd_t cmd;
  fbc_sts_t sts;

  fbc_regs #(.CACHE_LIMIT(CACHE_LIMIT), .DEFAULT_BATCH(DEFAULT_BATCH)) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbc_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item still in work");

  a_only_spill_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == K_SPILL)
    else $error("non-final result of a kind other than spill");

  a_cached_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CACHED_LSB +: CNT_W] <= CNT_W'(STACK_DEPTH))
    else $error("cached count beyond stack depth");

  a_fill_asks_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_FILL |-> out_tdata[REQ_LSB +: CNT_W] != '0)
    else $error("fill request for zero blocks");

endmodule

/* dv/tb.sv */
// Self-checking bench for free_block_cache_with_batch_refill_core: stream items in, results out.
// Needs fbc_pkg and the core; a built-in cache predictor checks every result field by field.
module tb import fbc_pkg::*; ();

  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [5:0]  cnt;
    logic        last;
    logic [5:0]  cached;
    logic        full;
  } cache_result_t;

  class cache_checker;
    localparam int CAP = 32;
    localparam int BATCH_DEF = 16;

    logic [31:0]   stack_mem [CAP];
    int            held;
    bit            fill_open;
    bit            alloc_parked;
    int            recv;
    int            max_reg = 32;
    int            batch_reg = 16;
    int            thresh_reg = 16;
    cache_result_t step_q [$];
    cache_result_t due_results [$];
    int            errors;
    int            items_seen;
    int            results_seen;
    int            kind_count [8];

    function void set_reg(logic [1:0] idx, logic [5:0] value);
      case (idx)
        REG_MAX:    max_reg = int'(value);
        REG_BATCH:  batch_reg = int'(value);
        REG_THRESH: thresh_reg = int'(value);
        default: ;
      endcase
    endfunction

    function int eff_max();
      int m = (max_reg == 0) ? CAP : max_reg;
      if (m > CAP) m = CAP;
      return m;
    endfunction

    function int eff_batch();
      int b = (batch_reg == 0) ? BATCH_DEF : batch_reg;
      int m = eff_max();
      return (b > m) ? m : b;
    endfunction

    function int fill_room();
      int m = eff_max();
      int b = eff_batch();
      int room = (held >= m) ? 0 : m - held;
      return (b < room) ? b : room;
    endfunction

    function void add_result(logic [2:0] kind, logic [31:0] addr, int cnt);
      cache_result_t r;
      r.kind = kind;
      r.addr = addr;
      r.cnt = cnt[5:0];
      r.last = 1'b0;
      r.cached = held[5:0];
      r.full = (held >= eff_max());
      step_q.push_back(r);
    endfunction

    function logic [31:0] pop_block();
      if (held == 0) return '0;
      held--;
      return stack_mem[held];
    endfunction

    function void push_block(logic [31:0] a);
      if (held < CAP) begin
        stack_mem[held] = a;
        held++;
      end
    endfunction

    function void note_item(logic [2:0] cmd, logic [31:0] addr);
      bit refuse;
      int need, keep, n, m;
      logic [31:0] a;
      step_q.delete();
      items_seen++;
      case (cmd)
        CMD_ALLOC, CMD_FREE, CMD_FILL_REQ, CMD_FLUSH: refuse = fill_open;
        CMD_DELIVER, CMD_FILL_END: refuse = !fill_open;
        default: refuse = 1'b1;
      endcase
      if (refuse) begin
        add_result(K_REFUSED, '0, 0);
      end else begin
        case (cmd)
          CMD_ALLOC: begin
            if (held > 0) begin
              a = pop_block();
              add_result(K_GRANT, a, 0);
            end else begin
              need = fill_room();
              if (need == 0) begin
                add_result(K_BYPASS, '0, 0);
              end else begin
                fill_open = 1'b1;
                alloc_parked = 1'b1;
                recv = 0;
                add_result(K_FILL, '0, need);
              end
            end
          end
          CMD_FREE: begin
            if (addr == '0) begin
              add_result(K_ACK, '0, 0);
            end else begin
              m = eff_max();
              if (held >= m && held > thresh_reg) begin
                keep = (thresh_reg > m / 2) ? m / 2 : thresh_reg;
                n = held - keep;
                if (n > eff_batch()) n = eff_batch();
                while (n > 0 && held > 0) begin
                  a = pop_block();
                  add_result(K_SPILL, a, 0);
                  n--;
                end
              end
              if (held >= m) begin
                add_result(K_SPILL, addr, 0);
              end else begin
                push_block(addr);
                add_result(K_ACK, '0, 0);
              end
            end
          end
          CMD_DELIVER: begin
            if (addr == '0) begin
              add_result(K_ACK, '0, recv);
            end else if (held >= eff_max()) begin
              add_result(K_SPILL, addr, 0);
            end else begin
              push_block(addr);
              if (recv < 63) recv++;
              add_result(K_ACK, '0, recv);
            end
          end
          CMD_FILL_END: begin
            fill_open = 1'b0;
            if (alloc_parked) begin
              alloc_parked = 1'b0;
              if (held > 0) begin
                a = pop_block();
                add_result(K_GRANT, a, 0);
              end else begin
                add_result(K_BYPASS, '0, 0);
              end
            end else begin
              add_result(K_ACK, '0, recv);
            end
          end
          CMD_FILL_REQ: begin
            need = fill_room();
            if (need == 0) begin
              add_result(K_ACK, '0, 0);
            end else begin
              fill_open = 1'b1;
              alloc_parked = 1'b0;
              recv = 0;
              add_result(K_FILL, '0, need);
            end
          end
          default: begin
            if (held == 0) begin
              add_result(K_ACK, '0, 0);
            end else begin
              while (held > 0) begin
                a = pop_block();
                add_result(K_SPILL, a, 0);
              end
            end
          end
        endcase
      end
      step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) due_results.push_back(step_q[i]);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [31:0] addr, logic [5:0] cnt,
                               logic last, logic [5:0] cached, logic full);
      cache_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: kind %0d addr %0h", kind, addr);
        errors++;
        return;
      end
      want = due_results.pop_front();
      results_seen++;
      kind_count[want.kind]++;
      compare("kind", 32'(want.kind), 32'(kind));
      compare("out_addr", want.addr, addr);
      compare("req_count", 32'(want.cnt), 32'(cnt));
      compare("last", 32'(want.last), 32'(last));
      compare("cached_now", 32'(want.cached), 32'(cached));
      compare("is_full", 32'(want.full), 32'(full));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic [2:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  cache_checker sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int settings_done = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  free_block_cache_with_batch_refill_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[31:0], out_tdata[37:32], out_tlast,
                      out_tdata[43:38], out_tdata[44]);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int mode, span, k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 60);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= (k % 3 == 0);
            default: out_tready <= ($urandom_range(0, 9) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [31:0] addr);
    int gap;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, addr);
    burst_left--;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [5:0] mx, logic [5:0] bt, logic [5:0] th);
    logic [1:0] regs [3];
    logic [5:0] vals [3];
    int i;
    regs = '{REG_MAX, REG_BATCH, REG_THRESH};
    vals = '{mx, bt, th};
    drain_results();
    repeat (4) @(posedge clk);
    for (i = 0; i < 3; i++) begin
      cfg_psel <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b1;
      cfg_paddr <= {regs[i], 2'b00};
      cfg_pwdata <= {26'd0, vals[i]};
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] stray_cmd(bit open);
    if (open) begin
      case ($urandom_range(0, 5))
        0: return CMD_ALLOC;
        1: return CMD_FREE;
        2: return CMD_FILL_REQ;
        3: return CMD_FLUSH;
        4: return CMD_UNUSED6;
        default: return CMD_UNUSED7;
      endcase
    end
    case ($urandom_range(0, 3))
      0: return CMD_DELIVER;
      1: return CMD_FILL_END;
      2: return CMD_UNUSED6;
      default: return CMD_UNUSED7;
    endcase
  endfunction

  function automatic void pick_item(int free_pct, output logic [2:0] cmd,
                                    output logic [31:0] addr);
    int r, s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    addr = rand_addr();
    if (sb.fill_open) begin
      if (r < 8) cmd = stray_cmd(1'b1);
      else if (r < 26) cmd = CMD_FILL_END;
      else cmd = CMD_DELIVER;
    end else if (r < 4) begin
      cmd = stray_cmd(1'b0);
    end else if (r < 4 + free_pct) begin
      cmd = CMD_FREE;
    end else if (s < 70) begin
      cmd = CMD_ALLOC;
    end else if (s < 92) begin
      cmd = CMD_FILL_REQ;
    end else begin
      cmd = CMD_FLUSH;
    end
  endfunction

  task automatic run_random(int n_items, int free_pct);
    logic [2:0] cmd;
    logic [31:0] addr;
    int i;
    for (i = 0; i < n_items; i++) begin
      pick_item(free_pct, cmd, addr);
      send_item(cmd, addr);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 32'h1234_5678);
    send_item(CMD_DELIVER, '0);
    send_item(CMD_DELIVER, 32'hFFFF_FFFF);
    send_item(CMD_DELIVER, 32'h0000_0001);
    send_item(CMD_FILL_END, '0);
    send_item(CMD_DELIVER, 32'h5A5A_5A5A);
    send_item(CMD_FILL_END, '0);
    send_item(CMD_UNUSED6, 32'h8000_0000);
    send_item(CMD_UNUSED7, '1);
    send_item(CMD_FREE, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FILL_END, '0);

    write_config(6'd4, 6'd2, 6'd1);
    send_item(CMD_FREE, 32'hA000_0001);
    send_item(CMD_FREE, 32'hA000_0002);
    send_item(CMD_FREE, 32'hA000_0003);
    send_item(CMD_FREE, 32'hA000_0004);
    send_item(CMD_FREE, 32'hA000_0005);
    write_config(6'd1, 6'd2, 6'd1);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 32'hB000_0001);
    send_item(CMD_FILL_REQ, '0);
    send_item(CMD_DELIVER, 32'hC000_0001);
    send_item(CMD_DELIVER, 32'hC000_0002);
    send_item(CMD_FILL_END, '0);
    send_item(CMD_FILL_REQ, '0);
    send_item(CMD_FLUSH, '0);
    send_item(CMD_FLUSH, '0);

    write_config(6'd0, 6'd0, 6'd0);
    run_random(35, 55);
    write_config(6'd32, 6'd16, 6'd16);
    hold_req = 1'b1;
    run_random(40, 60);
    write_config(6'd63, 6'd63, 6'd63);
    run_random(30, 50);
    write_config(6'd1, 6'd1, 6'd0);
    run_random(25, 45);
    write_config(6'd5, 6'd2, 6'd1);
    run_random(30, 50);
    write_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)));
    run_random(16, 50);
    write_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)));
    run_random(16, 50);

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.due_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.due_results.size());
      sb.errors++;
    end
    $display("Sent %0d items across %0d register settings; checked %0d results.",
             sb.items_seen, settings_done, sb.results_seen);
    $display("Grants %0d, fills %0d, spills %0d, bypasses %0d, acks %0d, refusals %0d.",
             sb.kind_count[K_GRANT], sb.kind_count[K_FILL], sb.kind_count[K_SPILL],
             sb.kind_count[K_BYPASS], sb.kind_count[K_ACK], sb.kind_count[K_REFUSED]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* free_block_cache_with_batch_refill_core.f */
sv/fbc_pkg.sv
sv/fbc_ram.sv
sv/fbc_regs.sv
sv/fbc_ctrl.sv
sv/fbc_dp.sv
sv/free_block_cache_with_batch_refill_core.sv
dv/tb.sv
